// ----- hdl/nfcrd_pkg.sv -----
// ----------------------------------------------------------------------------
// nfcrd_pkg
// Types and constants shared by the response deframer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcrd_pkg;

  localparam int unsigned TRANSFER_BYTES = 32;
  localparam int unsigned START_LIMIT    = 20;
  localparam int unsigned POS_W          = 6;

  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd20;
  localparam logic [7:0] SYNC_ZERO       = 8'h00;
  localparam logic [7:0] SYNC_FF         = 8'hFF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HEADER = 2'd1,
    ST_ZERO_LEN  = 2'd2,
    ST_SHORT     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_SEARCH   = 3'd0,
    PH_CHECKSUM = 3'd1,
    PH_TFI      = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_transfer;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
    logic [7:0] payload_count;
    logic       last;
  } out_beat_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/nfc_response_deframer.sv -----
// ----------------------------------------------------------------------------
// nfc_response_deframer
// Finds the information frame in a serial read transfer and delivers its
// payload bytes plus one summary beat per transfer.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while in_ready is high. Each byte
// updates the frame state in the cycle it is accepted and its results are
// registered into a four-entry output queue. A final byte that also
// carries a payload byte yields two beats; in_ready is high while at least
// two queue slots are free, so with the output side always ready the block
// sustains one byte per cycle.
`default_nettype none

module nfc_response_deframer
  import nfcrd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  logic [7:0]       max_payload;
  logic [POS_W-1:0] position, position_next;
  logic [23:0]      recent_bytes, recent_bytes_next;
  phase_t           phase, phase_next;
  logic [7:0]       remaining, remaining_next;
  logic [7:0]       delivered, delivered_next;
  logic [7:0]       clipped_length, clipped_length_next;

  out_beat_t        queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  logic       accept, pop;
  logic [7:0] b;
  logic [7:0] len1;
  logic       in_window, header_hit, emit_payload;
  out_beat_t  pay_beat, sum_beat, beat0;
  logic [1:0] push_n;
  status_t    sum_status;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = count <= QCNT_W'(QDEPTH - 2);
  assign b        = bit_rev8(in_data.rx_byte);
  assign len1     = b - 8'd1;

  assign in_window = (position >= POS_W'(3)) && (position <= POS_W'(START_LIMIT));
  assign header_hit = in_window && recent_bytes[23:16] == SYNC_ZERO &&
                      recent_bytes[15:8] == SYNC_ZERO && recent_bytes[7:0] == SYNC_FF &&
                      b != SYNC_ZERO;

  always_comb begin
    position_next       = position;
    recent_bytes_next   = recent_bytes;
    phase_next          = phase;
    remaining_next      = remaining;
    delivered_next      = delivered;
    clipped_length_next = clipped_length;
    emit_payload        = 1'b0;

    if (position < POS_W'(TRANSFER_BYTES)) begin
      unique case (phase)
        PH_SEARCH: begin
          if (header_hit) begin
            clipped_length_next = (len1 > max_payload) ? max_payload : len1;
            remaining_next      = clipped_length_next;
            delivered_next      = 8'd0;
            phase_next          = (clipped_length_next == 8'd0) ? PH_DONE : PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: phase_next = PH_TFI;
        PH_TFI:      phase_next = PH_PAYLOAD;
        PH_PAYLOAD: begin
          emit_payload   = 1'b1;
          delivered_next = delivered + 8'd1;
          remaining_next = remaining - 8'd1;
          if (remaining_next == 8'd0) begin
            phase_next = PH_DONE;
          end
        end
        default: phase_next = PH_DONE;
      endcase
      recent_bytes_next = {recent_bytes[15:0], b};
      position_next     = position + POS_W'(1);
    end

    priority if (phase_next == PH_SEARCH) begin
      sum_status = ST_NO_HEADER;
    end else if (phase_next == PH_DONE) begin
      sum_status = (clipped_length_next == 8'd0) ? ST_ZERO_LEN : ST_OK;
    end else begin
      sum_status = ST_SHORT;
    end

    pay_beat = '{kind: KIND_PAYLOAD, payload_byte: b, byte_index: delivered,
                 status: ST_OK, payload_count: 8'd0, last: 1'b0};
    sum_beat = '{kind: KIND_SUMMARY, payload_byte: 8'd0, byte_index: 8'd0,
                 status: sum_status,
                 payload_count: (phase_next == PH_SEARCH) ? 8'd0 : clipped_length_next,
                 last: 1'b1};
    beat0  = emit_payload ? pay_beat : sum_beat;
    push_n = accept ? ({1'b0, emit_payload} + {1'b0, in_data.end_of_transfer}) : 2'd0;

    if (accept && in_data.end_of_transfer) begin
      position_next       = '0;
      recent_bytes_next   = '0;
      phase_next          = PH_SEARCH;
      remaining_next      = 8'd0;
      delivered_next      = 8'd0;
      clipped_length_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= MAX_PAYLOAD_RST;
      position       <= '0;
      recent_bytes   <= '0;
      phase          <= PH_SEARCH;
      remaining      <= 8'd0;
      delivered      <= 8'd0;
      clipped_length <= 8'd0;
    end else begin
      if (cfg_we) begin
        max_payload <= cfg_wdata;
      end
      if (accept) begin
        position       <= position_next;
        recent_bytes   <= recent_bytes_next;
        phase          <= phase_next;
        remaining      <= remaining_next;
        delivered      <= delivered_next;
        clipped_length <= clipped_length_next;
      end
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= beat0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= sum_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  assign out_valid = count != '0;
  assign out_data  = queue[rd_ptr];

endmodule

`default_nettype wire

// ----- hdl/nfcrd_checker.sv -----
// ----------------------------------------------------------------------------
// nfcrd_checker
// Port-level checks for the response deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcrd_checker
  import nfcrd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire out_beat_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_PAYLOAD |->
      !out_data.last && out_data.status == ST_OK && out_data.payload_count == 8'd0)
    else $error("payload beat carries summary fields");

  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_SUMMARY |->
      out_data.last && out_data.payload_byte == 8'd0 && out_data.byte_index == 8'd0)
    else $error("summary beat carries payload fields");

  a_no_header_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_SUMMARY && out_data.status == ST_NO_HEADER |->
      out_data.payload_count == 8'd0)
    else $error("no-header summary with nonzero count");

  a_zero_len_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_SUMMARY && out_data.status == ST_ZERO_LEN |->
      out_data.payload_count == 8'd0)
    else $error("zero-length summary with nonzero count");

endmodule

bind nfc_response_deframer nfcrd_checker u_nfcrd_checker (.*);

`default_nettype wire

// ----- test/deframer_checker.sv -----
// ----------------------------------------------------------------------------
// deframer_checker
// Watches both channels and the register port of the response deframer,
// keeps its own model of the frame search, and compares every output beat
// field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module deframer_checker
  import nfcrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_beat_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         outstanding,
  output int         payload_seen,
  output int         summary_seen
);

  logic [POS_W-1:0] byte_pos;
  logic [23:0]      window;
  phase_t           frame_phase;
  logic [7:0]       left_to_send;
  logic [7:0]       sent_count;
  logic [7:0]       clip_len;
  logic [7:0]       max_payload_q;
  out_beat_t        expected_beats[$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    payload_seen = 0;
    summary_seen = 0;
  end

  function automatic logic [7:0] swap_bit_order(input logic [7:0] v);
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  task automatic clear_frame();
    byte_pos     = '0;
    window       = '0;
    frame_phase  = PH_SEARCH;
    left_to_send = '0;
    sent_count   = '0;
    clip_len     = '0;
  endtask

  task automatic predict_frame_byte(input in_beat_t beat);
    logic [7:0] b;
    logic [7:0] len_m1;
    out_beat_t  r;
    b = swap_bit_order(beat.rx_byte);
    if (byte_pos < POS_W'(TRANSFER_BYTES)) begin
      case (frame_phase)
        PH_SEARCH: begin
          if (byte_pos >= POS_W'(3) && byte_pos <= POS_W'(START_LIMIT) &&
              window == {SYNC_ZERO, SYNC_ZERO, SYNC_FF} && b != SYNC_ZERO) begin
            len_m1       = b - 8'd1;
            clip_len     = (len_m1 > max_payload_q) ? max_payload_q : len_m1;
            left_to_send = clip_len;
            sent_count   = '0;
            frame_phase  = (clip_len == 8'd0) ? PH_DONE : PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: frame_phase = PH_TFI;
        PH_TFI:      frame_phase = PH_PAYLOAD;
        PH_PAYLOAD: begin
          r = '0;
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
          r.byte_index   = sent_count;
          expected_beats.push_back(r);
          sent_count++;
          left_to_send--;
          if (left_to_send == 8'd0) begin
            frame_phase = PH_DONE;
          end
        end
        default: frame_phase = PH_DONE;
      endcase
      window = {window[15:0], b};
      byte_pos++;
    end
    if (beat.end_of_transfer) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.last = 1'b1;
      if (frame_phase == PH_SEARCH) begin
        r.status = ST_NO_HEADER;
      end else if (frame_phase == PH_DONE) begin
        r.status        = (clip_len == 8'd0) ? ST_ZERO_LEN : ST_OK;
        r.payload_count = clip_len;
      end else begin
        r.status        = ST_SHORT;
        r.payload_count = clip_len;
      end
      expected_beats.push_back(r);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_out_beat(input out_beat_t got);
    out_beat_t want;
    if (expected_beats.size() == 0) begin
      $error("output beat 0x%h with nothing expected", got);
      fail_count++;
    end else begin
      want = expected_beats.pop_front();
      check_field("kind", 8'(want.kind), 8'(got.kind));
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("payload_count", want.payload_count, got.payload_count);
      check_field("last", 8'(want.last), 8'(got.last));
      if (want.kind == KIND_SUMMARY) begin
        summary_seen++;
      end else begin
        payload_seen++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      max_payload_q = MAX_PAYLOAD_RST;
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_out_beat(out_data);
      end
      if (cfg_we) begin
        max_payload_q = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        predict_frame_byte(in_data);
      end
    end
    outstanding <= expected_beats.size();
  end

endmodule

// ----- test/tb_nfc_response_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_nfc_response_deframer
// Drives read transfers into the response deframer: a few hand-built frames
// for the corner cases, then random frames and noise under several
// max_payload settings, with random idling on both sides and one long
// output stall. A separate checker predicts and compares the output beats.
// ----------------------------------------------------------------------------
module tb_nfc_response_deframer;
  import nfcrd_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_beat_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int payload_seen;
  int summary_seen;

  int in_gap_max;
  int out_gap_max;
  bit hold_off_req;
  bit hold_done;
  int bytes_sent;
  int transfers_sent;
  int settings_used;

  logic [7:0] xfer[$];

  nfc_response_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  deframer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .payload_seen (payload_seen),
    .summary_seen (summary_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] wire_order(input logic [7:0] v);
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  function automatic logic [7:0] random_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  task automatic send_transfer();
    int       gap;
    in_beat_t beat;
    for (int i = 0; i < xfer.size(); i++) begin
      beat.rx_byte         = wire_order(xfer[i]);
      beat.end_of_transfer = (i == xfer.size() - 1);
      gap = $urandom_range(0, in_gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= beat;
      do @(posedge clk); while (!in_ready);
    end
    bytes_sent += xfer.size();
    transfers_sent++;
    xfer.delete();
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input bit write_cfg, input logic [7:0] cfg_value,
                           input int quota);
    int sent;
    int n;
    int len;
    int limit;
    sent = 0;
    if (write_cfg) begin
      cfg_we    <= 1'b1;
      cfg_wdata <= cfg_value;
      @(posedge clk);
      cfg_we    <= 1'b0;
    end
    settings_used++;
    while (sent < quota) begin
      case ($urandom_range(0, 3))
        0: begin in_gap_max = 0;  out_gap_max = 0;  end
        1: begin in_gap_max = 11; out_gap_max = 11; end
        2: begin in_gap_max = 0;  out_gap_max = 11; end
        default: begin in_gap_max = 11; out_gap_max = 2; end
      endcase
      if ($urandom_range(0, 9) < 3) begin
        // noise, biased toward sync bytes to form partial headers
        n = $urandom_range(1, 40);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       xfer.push_back(SYNC_ZERO);
            1:       xfer.push_back(SYNC_FF);
            default: xfer.push_back(random_byte());
          endcase
        end
      end else begin
        limit = ($urandom_range(0, 3) == 0) ? 44 : TRANSFER_BYTES;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
        repeat (n) xfer.push_back(random_byte());
        if ($urandom_range(0, 4) == 0) begin
          xfer.push_back(SYNC_ZERO);
          xfer.push_back(SYNC_ZERO);
          xfer.push_back(SYNC_FF);
          xfer.push_back(SYNC_ZERO);
        end
        xfer.push_back(SYNC_ZERO);
        xfer.push_back(SYNC_ZERO);
        xfer.push_back(SYNC_FF);
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 14);
        xfer.push_back(len[7:0]);
        xfer.push_back(random_byte());
        xfer.push_back(random_byte());
        n = len - 1 + $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(0, len - 1);
        end
        while (n > 0 && xfer.size() < limit) begin
          xfer.push_back(random_byte());
          n--;
        end
      end
      sent += xfer.size();
      send_transfer();
    end
    in_valid <= 1'b0;
    wait_idle();
  endtask

  initial begin : stimulus
    logic [7:0] cfg_pick;
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_gap_max     = 11;
    out_gap_max    = 11;
    hold_off_req   = 1'b0;
    bytes_sent     = 0;
    transfers_sent = 0;
    settings_used  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // sync pattern too early in the window, then end of transfer
    xfer = '{SYNC_FF, 8'h05};
    send_transfer();
    // ACK frame skipped, two-byte payload, last payload beat carries the end
    xfer = '{SYNC_ZERO, SYNC_ZERO, SYNC_FF, SYNC_ZERO, SYNC_ZERO, SYNC_FF,
             8'h03, 8'h5A, 8'hD5, SYNC_FF, SYNC_ZERO};
    send_transfer();
    // zero length
    xfer = '{SYNC_ZERO, SYNC_ZERO, SYNC_FF, 8'h01, 8'hAA};
    send_transfer();
    // transfer ends inside the payload
    xfer = '{SYNC_ZERO, SYNC_ZERO, SYNC_FF, 8'h0A, 8'hF7, 8'hD5, 8'h55};
    send_transfer();

    run_phase(1'b0, 8'd0, 100);
    run_phase(1'b1, 8'd0, 60);
    hold_off_req = 1'b1;
    run_phase(1'b1, 8'd255, 120);
    run_phase(1'b1, 8'd1, 60);
    run_phase(1'b1, 8'd3, 90);
    cfg_pick = random_byte();
    run_phase(1'b1, cfg_pick, 90);
    cfg_pick = 8'($urandom_range(4, 30));
    run_phase(1'b1, cfg_pick, 100);

    repeat (8) @(posedge clk);
    $display("Drove %0d bytes in %0d transfers under %0d max_payload settings",
             bytes_sent, transfers_sent, settings_used);
    $display("Checked %0d payload beats and %0d transfer summaries",
             payload_seen, summary_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : receiver
    int gap;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        // long stall so the output queue fills and input backs up
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    #(20 * 300000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
